### design/orf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package orf_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 64;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int FILL_W     = 7;
    localparam int REQ_W      = 2;
    localparam int STAT_W     = 2;
    localparam int OUT_TDATA_W = ((DATA_WIDTH + FILL_W + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT  = 2'd0,
        REQ_GET  = 2'd1,
        REQ_PEEK = 2'd2,
        REQ_DUMP = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_OVERWRITE = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_DATA
    } t_state;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [DATA_WIDTH-1:0] wr_data;
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
    } t_ram_req;

    // step a pointer by one, wrapping at the active depth
    function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] ptr,
                                                  input logic [CNT_W-1:0]  depth);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(ptr) + CNT_W'(1);
        if (nxt >= depth) begin
            return '0;
        end
        return nxt[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

### design/orf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module orf_ram (
    input  wire logic                          i_clk,
    input  wire orf_pkg::t_ram_req             i_req,
    output logic [orf_pkg::DATA_WIDTH-1:0]     o_rdata
);

    logic [orf_pkg::DATA_WIDTH-1:0] r_mem [orf_pkg::DEPTH];
    logic [orf_pkg::DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/overwriting_ring_fifo_unit.sv
// Ring FIFO of 64-bit words over a 64-entry synchronous store, with the number
// of slots in use set through the configuration channel (0 acts as 1, values
// above 64 act as 64; any write empties the FIFO but keeps the stored words).
// Requests arrive on the slave stream with the request kind in tuser: put,
// get, peek or dump. A put into a full FIFO overwrites the oldest word and
// reports an overwrite status. Every request gives one result beat with tlast
// set, except a non-empty dump, which gives one beat per stored word, oldest
// first, tlast on the final one. Results sit in an output register, and a new
// request is taken only in the idle state and while that register is empty or
// its beat leaves in the same cycle. A put, or any request on an empty FIFO,
// is answered straight into the output register; otherwise each word of a
// get, peek or dump comes through the store's single registered read port
// and is pushed once the output register frees. No clearing pass is run
// after reset.
`timescale 1ns / 1ps
`default_nettype none

module overwriting_ring_fifo_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration: active depth
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [orf_pkg::FILL_W-1:0]         i_cfg_data,
    // request stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [orf_pkg::DATA_WIDTH-1:0]     s_axis_tdata,   // data_in
    input  wire logic [orf_pkg::REQ_W-1:0]          s_axis_tuser,   // req_type
    // result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [orf_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,   // data_out, fill_count, zero pad
    output logic [orf_pkg::STAT_W-1:0]              m_axis_tuser,   // status
    output logic                                    m_axis_tlast
);

    orf_pkg::t_state               r_state, n_state;
    logic [orf_pkg::ADDR_W-1:0]    r_rp, n_rp;
    logic [orf_pkg::ADDR_W-1:0]    r_wp, n_wp;
    logic [orf_pkg::CNT_W-1:0]     r_count, n_count;
    logic [orf_pkg::CNT_W-1:0]     r_depth, n_depth;
    logic [orf_pkg::ADDR_W-1:0]    r_walk, n_walk;
    logic [orf_pkg::CNT_W-1:0]     r_left, n_left;
    logic [orf_pkg::CNT_W-1:0]     r_fill, n_fill;
    logic                          r_out_valid, n_out_valid;

    logic [orf_pkg::DATA_WIDTH-1:0] r_out_data, n_out_data;
    orf_pkg::t_status               r_out_status, n_out_status;
    logic [orf_pkg::CNT_W-1:0]      r_out_fill, n_out_fill;
    logic                           r_out_last, n_out_last;

    orf_pkg::t_ram_req              w_ram_req;
    logic [orf_pkg::DATA_WIDTH-1:0] w_rdata;
    logic                           w_out_free;
    logic                           w_in_acc;
    logic                           w_cfg_acc;
    orf_pkg::t_req                  w_req;
    logic [orf_pkg::FILL_W-1:0]     w_cfg_depth;

    orf_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_rdata)
    );

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == orf_pkg::S_IDLE) && w_out_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign w_cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign w_req         = orf_pkg::t_req'(s_axis_tuser);

    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_depth = orf_pkg::FILL_W'(1);
        end else if (i_cfg_data > orf_pkg::FILL_W'(orf_pkg::DEPTH)) begin
            w_cfg_depth = orf_pkg::FILL_W'(orf_pkg::DEPTH);
        end else begin
            w_cfg_depth = i_cfg_data;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_rp         = r_rp;
        n_wp         = r_wp;
        n_count      = r_count;
        n_depth      = r_depth;
        n_walk       = r_walk;
        n_left       = r_left;
        n_fill       = r_fill;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_fill   = r_out_fill;
        n_out_last   = r_out_last;
        w_ram_req    = '0;
        w_ram_req.wr_data = s_axis_tdata;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            orf_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (w_req == orf_pkg::REQ_PUT) begin
                        w_ram_req.wr_en   = 1'b1;
                        w_ram_req.wr_addr = r_wp;
                        n_wp = orf_pkg::advance(r_wp, r_depth);
                        if (r_count >= r_depth) begin
                            n_rp         = orf_pkg::advance(r_rp, r_depth);
                            n_out_status = orf_pkg::STAT_OVERWRITE;
                        end else begin
                            n_count      = r_count + orf_pkg::CNT_W'(1);
                            n_out_status = orf_pkg::STAT_OK;
                        end
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                        n_out_fill  = n_count;
                        n_out_last  = 1'b1;
                    end else if (r_count == '0) begin
                        n_out_valid  = 1'b1;
                        n_out_data   = '0;
                        n_out_status = orf_pkg::STAT_EMPTY;
                        n_out_fill   = '0;
                        n_out_last   = 1'b1;
                    end else begin
                        w_ram_req.rd_en   = 1'b1;
                        w_ram_req.rd_addr = r_rp;
                        n_walk  = orf_pkg::advance(r_rp, r_depth);
                        n_left  = (w_req == orf_pkg::REQ_DUMP) ? r_count
                                                               : orf_pkg::CNT_W'(1);
                        if (w_req == orf_pkg::REQ_GET) begin
                            n_rp    = orf_pkg::advance(r_rp, r_depth);
                            n_count = r_count - orf_pkg::CNT_W'(1);
                        end
                        n_fill  = n_count;
                        n_state = orf_pkg::S_DATA;
                    end
                end
            end
            orf_pkg::S_DATA: begin
                // store word is ready: push it once the output register frees
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = w_rdata;
                    n_out_status = orf_pkg::STAT_OK;
                    n_out_fill   = r_fill;
                    n_out_last   = (r_left == orf_pkg::CNT_W'(1));
                    if (r_left == orf_pkg::CNT_W'(1)) begin
                        n_state = orf_pkg::S_IDLE;
                    end else begin
                        w_ram_req.rd_en   = 1'b1;
                        w_ram_req.rd_addr = r_walk;
                        n_walk = orf_pkg::advance(r_walk, r_depth);
                        n_left = r_left - orf_pkg::CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = orf_pkg::S_IDLE;
            end
        endcase

        if (w_cfg_acc) begin
            n_depth = orf_pkg::CNT_W'(w_cfg_depth);
            n_rp    = '0;
            n_wp    = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= orf_pkg::S_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_count     <= '0;
            r_depth     <= orf_pkg::CNT_W'(orf_pkg::DEPTH);
            r_walk      <= '0;
            r_left      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_count     <= n_count;
            r_depth     <= n_depth;
            r_walk      <= n_walk;
            r_left      <= n_left;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_fill   <= n_out_fill;
        r_out_last   <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(orf_pkg::OUT_TDATA_W - orf_pkg::DATA_WIDTH - orf_pkg::FILL_W)'(0),
                            orf_pkg::FILL_W'(r_out_fill), r_out_data};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

### design/orf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module orf_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic [orf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  wire logic [orf_pkg::STAT_W-1:0]         m_axis_tuser,
    input  wire logic                               m_axis_tlast
);

    localparam int FILL_LO = orf_pkg::DATA_WIDTH;
    localparam int FILL_HI = orf_pkg::DATA_WIDTH + orf_pkg::FILL_W - 1;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    a_no_beat_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat right after reset");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[FILL_HI:FILL_LO] <= orf_pkg::FILL_W'(orf_pkg::DEPTH))
        else $error("fill count above depth");

    // empty answers are single zero beats with nothing held
    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == orf_pkg::STAT_EMPTY |->
            m_axis_tlast && m_axis_tdata == '0)
        else $error("malformed empty beat");

    // an overwrite only happens on a full fifo, so something is held
    a_overwrite_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == orf_pkg::STAT_OVERWRITE |->
            m_axis_tlast && m_axis_tdata[FILL_HI:FILL_LO] != '0
            && m_axis_tdata[orf_pkg::DATA_WIDTH-1:0] == '0)
        else $error("malformed overwrite beat");

endmodule

bind overwriting_ring_fifo_unit orf_checker u_orf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
